// File: design/eps_pkg.sv
// Package for the encoder period speed meter.
// Holds item types, register codes, controller states, command and status structs.
// No dependencies.
package eps_pkg;

	localparam int DIV_STEPS = 16;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);

	localparam logic [15:0] RST_DIST_NUM = 16'd220;
	localparam logic [15:0] RST_DIST_DEN = 16'd360;
	localparam logic [31:0] RST_RPM_NUM  = 32'd4000000;
	localparam logic [31:0] RST_LIN_NUM  = 32'd14653333;

	typedef struct packed {
		logic        action;
		logic [15:0] capture_value;
	} eps_in_t;

	typedef struct packed {
		logic [15:0] distance_mm;
		logic [31:0] edge_total_out;
		logic [31:0] period_ticks;
		logic [15:0] wheel_rpm;
		logic [15:0] speed_mm_per_s;
	} eps_out_t;

	typedef enum logic [1:0] {
		REG_DIST_NUM,
		REG_DIST_DEN,
		REG_RPM_NUM,
		REG_LIN_NUM
	} eps_reg_t;

	typedef enum logic [1:0] {
		SEL_DIST,
		SEL_RPM,
		SEL_LIN
	} eps_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DGO,
		S_DRUN,
		S_RGO,
		S_RRUN,
		S_LGO,
		S_LRUN,
		S_OUT
	} eps_state_t;

	typedef struct packed {
		logic     tick;
		logic     capture;
		logic     mul_en;
		logic     div_start;
		logic     q_load;
		eps_sel_t sel;
		logic     out_load;
	} eps_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} eps_sts_t;

endpackage

// File: design/eps_div.sv
// Shared restoring divider: 16 quotient bits, one per cycle, saturating to 16 bits.
// Expects the high part of the dividend; saturates when it is not below the divisor.
// Depends on eps_pkg.
module eps_div
	import eps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] hi,
	input  logic [15:0] lo,
	input  logic [31:0] dvs,
	output logic        done,
	output logic [15:0] quo
);

	logic [31:0]         rem_q;
	logic [15:0]         lo_q;
	logic [31:0]         dvs_q;
	logic [15:0]         quo_q;
	logic                sat_q;
	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [32:0]         trial;
	logic [32:0]         diff;

	assign trial = {rem_q, lo_q[15]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi;
			lo_q  <= lo;
			dvs_q <= dvs;
			quo_q <= '0;
			sat_q <= (hi >= dvs);
		end else if (run_q) begin
			lo_q <= {lo_q[14:0], 1'b0};
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = sat_q ? 16'hFFFF : quo_q;

endmodule

// File: design/eps_dp.sv
// Datapath: edge count, period base, product register, quotient and result registers.
// Runs the shared divider on operands picked by the controller.
// Depends on eps_pkg and eps_div.
module eps_dp
	import eps_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  eps_in_t     in_data,
	input  logic [15:0] dist_num,
	input  logic [15:0] dist_den,
	input  logic [31:0] rpm_num,
	input  logic [31:0] lin_num,
	input  eps_cmd_t    cmd,
	input  logic        out_stall,
	output eps_sts_t    sts,
	output logic        out_valid,
	output eps_out_t    out_data
);

	localparam logic [32:0] SPAN = 33'd1 << TIMER_BITS;
	localparam logic [31:0] MASK = 32'(SPAN - 33'd1);

	logic [31:0] edge_total_q;
	logic [31:0] period_base_q;
	logic [31:0] period_q;
	logic [47:0] prod_s1;
	logic [15:0] dist_q;
	logic [15:0] rpm_q;
	logic [15:0] lin_q;
	eps_out_t    out_q;
	logic        out_valid_q;
	logic [31:0] cap;
	logic [31:0] div_hi;
	logic [15:0] div_lo;
	logic [31:0] div_dvs;
	logic        div_done;
	logic [15:0] div_quo;

	assign cap = {16'd0, in_data.capture_value} & MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q  <= '0;
			period_base_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.tick) begin
				period_base_q <= period_base_q + SPAN[31:0];
			end else if (cmd.capture) begin
				edge_total_q  <= edge_total_q + 32'd1;
				period_base_q <= 32'd0 - cap;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			period_q <= cap + period_base_q;
		end
		if (cmd.mul_en) begin
			prod_s1 <= edge_total_q * {32'd0, dist_num};
		end
		if (cmd.q_load) begin
			case (cmd.sel)
				SEL_DIST: dist_q <= div_quo;
				SEL_RPM:  rpm_q  <= div_quo;
				default:  lin_q  <= div_quo;
			endcase
		end
		if (cmd.out_load) begin
			out_q.distance_mm    <= dist_q;
			out_q.edge_total_out <= edge_total_q;
			out_q.period_ticks   <= period_q;
			out_q.wheel_rpm      <= rpm_q;
			out_q.speed_mm_per_s <= lin_q;
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_DIST: begin
				div_hi  = prod_s1[47:16];
				div_lo  = prod_s1[15:0];
				div_dvs = {16'd0, dist_den};
			end
			SEL_RPM: begin
				div_hi  = {16'd0, rpm_num[31:16]};
				div_lo  = rpm_num[15:0];
				div_dvs = period_q;
			end
			default: begin
				div_hi  = {16'd0, lin_num[31:16]};
				div_lo  = lin_num[15:0];
				div_dvs = period_q;
			end
		endcase
	end

	eps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.hi     (div_hi),
		.lo     (div_lo),
		.dvs    (div_dvs),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

// File: design/eps_ctrl.sv
// Controller: sequences multiply, three divisions and the result load per capture.
// Drives input stall and the datapath commands.
// Depends on eps_pkg.
module eps_ctrl
	import eps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_action,
	input  eps_sts_t sts,
	output logic     in_stall,
	output eps_cmd_t cmd
);

	eps_state_t state_q;
	eps_state_t state_nx;
	logic       accept;

	assign accept = in_valid && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (accept && in_action) state_nx = S_MUL;
			S_MUL:  state_nx = S_DGO;
			S_DGO:  state_nx = S_DRUN;
			S_DRUN: if (sts.div_done) state_nx = S_RGO;
			S_RGO:  state_nx = S_RRUN;
			S_RRUN: if (sts.div_done) state_nx = S_LGO;
			S_LGO:  state_nx = S_LRUN;
			S_LRUN: if (sts.div_done) state_nx = S_OUT;
			S_OUT:  if (sts.out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = SEL_DIST;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.tick    = accept && !in_action;
				cmd.capture = accept && in_action;
			end
			S_MUL: cmd.mul_en = 1'b1;
			S_DGO: cmd.div_start = 1'b1;
			S_DRUN: cmd.q_load = sts.div_done;
			S_RGO: begin
				cmd.sel       = SEL_RPM;
				cmd.div_start = 1'b1;
			end
			S_RRUN: begin
				cmd.sel    = SEL_RPM;
				cmd.q_load = sts.div_done;
			end
			S_LGO: begin
				cmd.sel       = SEL_LIN;
				cmd.div_start = 1'b1;
			end
			S_LRUN: begin
				cmd.sel    = SEL_LIN;
				cmd.q_load = sts.div_done;
			end
			S_OUT: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// File: design/encoder_period_speed_meter_unit.sv
// Top level of the encoder period speed meter: APB register bank, controller, datapath.
// Depends on eps_pkg, eps_ctrl, eps_dp.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_data  (eps_in_t)
//   out      out_valid / out_stall out_data (eps_out_t)
//   cfg      psel/penable/pwrite   paddr, pwdata, prdata
//
// An overflow tick is taken without leaving the idle state. A capture runs from acceptance to
// the result load through a multiply and three 16-step divisions on one shared divider.
// Reset clears the edge count, the period base and the registers to their defaults.
// A waiting result sits in the output register; the next item is taken meanwhile,
// and a capture only stalls at its load if the previous result is still not taken.
module encoder_period_speed_meter_unit
	import eps_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  eps_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output eps_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] dist_num_q;
	logic [15:0] dist_den_q;
	logic [31:0] rpm_num_q;
	logic [31:0] lin_num_q;
	eps_reg_t    reg_sel;
	logic        wr_en;
	eps_cmd_t    cmd;
	eps_sts_t    sts;

	assign pready  = 1'b1;
	assign reg_sel = eps_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_num_q <= RST_DIST_NUM;
			dist_den_q <= RST_DIST_DEN;
			rpm_num_q  <= RST_RPM_NUM;
			lin_num_q  <= RST_LIN_NUM;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DIST_NUM: dist_num_q <= pwdata[15:0];
				REG_DIST_DEN: dist_den_q <= pwdata[15:0];
				REG_RPM_NUM:  rpm_num_q  <= pwdata;
				REG_LIN_NUM:  lin_num_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DIST_NUM: prdata = {16'd0, dist_num_q};
			REG_DIST_DEN: prdata = {16'd0, dist_den_q};
			REG_RPM_NUM:  prdata = rpm_num_q;
			REG_LIN_NUM:  prdata = lin_num_q;
			default:      prdata = '0;
		endcase
	end

	eps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.sts       (sts),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	eps_dp #(
		.TIMER_BITS (TIMER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.dist_num  (dist_num_q),
		.dist_den  (dist_den_q),
		.rpm_num   (rpm_num_q),
		.lin_num   (lin_num_q),
		.cmd       (cmd),
		.out_stall (out_stall),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result loaded over a waiting item");

	a_qload_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.q_load |-> sts.div_done)
		else $error("quotient stored before divider done");

	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.period_ticks == 32'd0) |->
		(out_data.wheel_rpm == 16'hFFFF && out_data.speed_mm_per_s == 16'hFFFF))
		else $error("zero period without saturated speeds");

	a_start_idle_in: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> in_stall)
		else $error("divider started while input open");
`endif

endmodule
